FILE: design/grcc_pkg.sv
// ----------------------------------------------------------------------------
// grcc_pkg: shared types for the grid cell radiative cooling unit
// Register codes, configuration bundle and the records passed between modules.
// ----------------------------------------------------------------------------
package grcc_pkg;

  localparam int DATA_W = 32;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_AMBIENT = 2'd0,
    REG_RATE    = 2'd1,
    REG_HOT     = 2'd2,
    REG_STEP    = 2'd3
  } reg_idx_t;

  // Configuration registers as one bundle
  typedef struct packed {
    logic [31:0] ambient;
    logic [31:0] rate;
    logic [31:0] hot;
    logic [31:0] step;
  } cfg_t;

  // Status of the cooling factor unit
  typedef struct packed {
    logic        busy;
    logic [63:0] factor;
  } fac_stat_t;

  // Per-item side information carried down the pipeline
  typedef struct packed {
    logic        clamped;
    logic        cool;
    logic [31:0] dr;
  } side_t;

  // One result transaction
  typedef struct packed {
    logic        cooled;
    logic        clamped;
    logic [31:0] temp;
  } res_t;

endpackage

FILE: design/grcc_factor.sv
// ----------------------------------------------------------------------------
// grcc_factor: cooling factor unit
// Computes floor(3*k*dt*2^(5F) / |hot-ambient|^4), saturated to 64 bits,
// with a shared d^4 multiplier and a bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module grcc_factor #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  grcc_pkg::cfg_t    cfg,
  output grcc_pkg::fac_stat_t stat
);
  import grcc_pkg::*;

  localparam int NUMW = 66 + 5 * FRAC_BITS;
  localparam int FW   = (NUMW > 192) ? NUMW : 192;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_ABS  = 6'b000010,
    F_SQ   = 6'b000100,
    F_D4   = 6'b001000,
    F_CHK  = 6'b010000,
    F_DIV  = 6'b100000
  } fstate_t;

  fstate_t           state_r, state_nxt;
  logic [31:0]       d_r;
  logic [63:0]       kt_r;
  logic [63:0]       d2_r;
  logic [65:0]       num_r;
  logic [127:0]      d4_r;
  logic [NUMW-1:0]   rem_r;
  logic [190:0]      dv_r;
  logic [63:0]       q_r;
  logic [5:0]        cnt_r;
  logic [63:0]       factor_r;
  logic              zero_r;

  logic [32:0]       diff, absd;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;
  logic [127:0]      d4_term;
  logic [FW-1:0]     num_sh, lim, dv_w, rem_w, rem_sub;
  logic              sat, ge;

  // Distance between hot point and ambient
  assign diff = {cfg.hot[31], cfg.hot} - {cfg.ambient[31], cfg.ambient};
  assign absd = diff[32] ? (~diff + 33'd1) : diff;

  // Shared 32x32 multiplier for the fourth power
  assign mul_a = cnt_r[1] ? d2_r[63:32] : d2_r[31:0];
  assign mul_b = cnt_r[0] ? d2_r[63:32] : d2_r[31:0];
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    d4_term = 128'(mul_p);
      2'd3:    d4_term = 128'(mul_p) << 64;
      default: d4_term = 128'(mul_p) << 32;
    endcase
  end

  // Saturation check and divider compare
  assign num_sh  = FW'(num_r) << (5 * FRAC_BITS);
  assign lim     = FW'(d4_r) << 64;
  assign sat     = zero_r || (num_sh >= lim);
  assign rem_w   = FW'(rem_r);
  assign dv_w    = FW'(dv_r);
  assign ge      = rem_w >= dv_w;
  assign rem_sub = rem_w - dv_w;

  // Sequence the steps
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: state_nxt = F_IDLE;
      F_ABS:  state_nxt = F_SQ;
      F_SQ:   state_nxt = F_D4;
      F_D4:   state_nxt = (cnt_r[1:0] == 2'd3) ? F_CHK : F_D4;
      F_CHK:  state_nxt = sat ? F_IDLE : F_DIV;
      F_DIV:  state_nxt = (cnt_r == 6'd0) ? F_IDLE : F_DIV;
      default: state_nxt = F_IDLE;
    endcase
    if (start) state_nxt = F_ABS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_ABS;
      cnt_r    <= 6'd0;
      factor_r <= 64'd0;
    end else begin
      state_r <= state_nxt;
      if (!start) begin
        unique case (state_r)
          F_SQ: cnt_r <= 6'd0;
          F_D4: cnt_r <= cnt_r + 6'd1;
          F_CHK: begin
            cnt_r <= 6'd63;
            if (sat) factor_r <= '1;
          end
          F_DIV: begin
            cnt_r <= cnt_r - 6'd1;
            if (cnt_r == 6'd0) factor_r <= {q_r[62:0], ge};
          end
          default: cnt_r <= cnt_r;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      F_ABS: begin
        d_r  <= absd[31:0];
        kt_r <= 64'(cfg.rate) * 64'(cfg.step);
      end
      F_SQ: begin
        d2_r   <= 64'(d_r) * 64'(d_r);
        num_r  <= 66'({kt_r, 1'b0}) + 66'(kt_r);
        zero_r <= (d_r == 32'd0);
        d4_r   <= 128'd0;
      end
      F_D4: d4_r <= d4_r + d4_term;
      F_CHK: begin
        rem_r <= num_sh[NUMW-1:0];
        dv_r  <= 191'(d4_r) << 63;
        q_r   <= 64'd0;
      end
      F_DIV: begin
        if (ge) rem_r <= rem_sub[NUMW-1:0];
        dv_r <= dv_r >> 1;
        q_r  <= {q_r[62:0], ge};
      end
      default: d_r <= d_r;
    endcase
  end

  assign stat.busy   = (state_r != F_IDLE);
  assign stat.factor = factor_r;

endmodule

FILE: design/grcc_pipe.sv
// ----------------------------------------------------------------------------
// grcc_pipe: per-cell cooling pipeline
// Clamp, cube and scale the excess, divide by one quotient bit per stage,
// then take the integer cube root one bit per stage.
// ----------------------------------------------------------------------------
module grcc_pipe #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [31:0]     cell_temp,
  input  grcc_pkg::cfg_t  cfg,
  input  logic [63:0]     factor,
  output logic            out_valid,
  output grcc_pkg::res_t  res
);
  import grcc_pkg::*;

  localparam int SH = 6 * FRAC_BITS;
  localparam int RW = 96 + SH;
  localparam int SW = ((SH > 160) ? SH : 160) + 1;
  localparam int CW = SW + 96;

  // Front stages
  logic         v1, v2, v3, v4, v5, v6, v7;
  side_t        sd1, sd2, sd3, sd4, sd5, sd6, sd7;
  logic [63:0]  sq2, plo3, phi3;
  logic [95:0]  cube4, cube5, cube6, cube7;
  logic [63:0]  pp5 [0:5];
  logic [127:0] row0_6, row1_6;
  logic [159:0] prod7;

  logic         lt;
  logic [31:0]  tc;
  logic [35:0]  ten;

  // Divider stages: index 0 is the loaded operand
  logic          dv_v [0:96];
  logic [RW-1:0] drem [0:96];
  logic [SW-1:0] dden [0:96];
  logic [95:0]   dq   [0:96];
  side_t         dsd  [0:96];

  // Cube root stages: index 0 is the divider result
  logic          rv   [0:32];
  logic [95:0]   rq   [0:32];
  logic [31:0]   rm   [0:32];
  logic [63:0]   rm2  [0:32];
  logic [95:0]   rm3  [0:32];
  side_t         rsd  [0:32];

  logic          fin_v;
  res_t          fin;
  logic [31:0]   m_sel;

  // Clamp to ambient
  assign lt  = $signed(cell_temp) < $signed(cfg.ambient);
  assign tc  = lt ? cfg.ambient : cell_temp;
  assign ten = (36'(sd1.dr) << 3) + (36'(sd1.dr) << 1);

  // Advance front valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1, v2, v3, v4, v5, v6, v7} <= '0;
      dv_v[0] <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      dv_v[0] <= v7;
    end
  end

  // Front payload: excess, its cube, and the factor product
  always_ff @(posedge clk) begin
    if (en) begin
      sd1 <= {lt, 1'b0, tc - cfg.ambient};

      sd2 <= {sd1.clamped,
              (cfg.rate != 32'd0) && (ten > (36'd1 << FRAC_BITS)),
              sd1.dr};
      sq2 <= 64'(sd1.dr) * 64'(sd1.dr);

      sd3  <= sd2;
      plo3 <= 64'(sq2[31:0]) * 64'(sd2.dr);
      phi3 <= 64'(sq2[63:32]) * 64'(sd2.dr);

      sd4   <= sd3;
      cube4 <= 96'(plo3) + (96'(phi3) << 32);

      sd5    <= sd4;
      cube5  <= cube4;
      pp5[0] <= 64'(factor[31:0])  * 64'(cube4[31:0]);
      pp5[1] <= 64'(factor[31:0])  * 64'(cube4[63:32]);
      pp5[2] <= 64'(factor[31:0])  * 64'(cube4[95:64]);
      pp5[3] <= 64'(factor[63:32]) * 64'(cube4[31:0]);
      pp5[4] <= 64'(factor[63:32]) * 64'(cube4[63:32]);
      pp5[5] <= 64'(factor[63:32]) * 64'(cube4[95:64]);

      sd6    <= sd5;
      cube6  <= cube5;
      row0_6 <= 128'(pp5[0]) + (128'(pp5[1]) << 32) + (128'(pp5[2]) << 64);
      row1_6 <= 128'(pp5[3]) + (128'(pp5[4]) << 32) + (128'(pp5[5]) << 64);

      sd7   <= sd6;
      cube7 <= cube6;
      prod7 <= 160'(row0_6) + (160'(row1_6) << 32);

      // Load divider: numerator cube<<6F, divisor 2^6F + f*cube
      dsd[0]  <= sd7;
      drem[0] <= RW'(cube7) << SH;
      dden[0] <= (SW'(1) << SH) + SW'(prod7);
      dq[0]   <= 96'd0;
    end
  end

  // Restoring divider, one quotient bit per stage
  for (genvar k = 0; k < 96; k++) begin : g_div
    localparam int B = 95 - k;
    logic [CW-1:0] shd, remx, dif;
    logic          ge;
    assign shd  = CW'(dden[k]) << B;
    assign remx = CW'(drem[k]);
    assign ge   = remx >= shd;
    assign dif  = remx - shd;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v[k+1] <= 1'b0;
      else if (en) dv_v[k+1] <= dv_v[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem[k+1] <= ge ? dif[RW-1:0] : drem[k];
        dden[k+1] <= dden[k];
        dq[k+1]   <= {dq[k][94:0], ge};
        dsd[k+1]  <= dsd[k];
      end
    end
  end

  assign rv[0]  = dv_v[96];
  assign rq[0]  = dq[96];
  assign rm[0]  = 32'd0;
  assign rm2[0] = 64'd0;
  assign rm3[0] = 96'd0;
  assign rsd[0] = dsd[96];

  // Integer cube root, one result bit per stage, tracking m^2 and m^3
  for (genvar k = 0; k < 32; k++) begin : g_root
    localparam int B = 31 - k;
    logic [95:0] t3;
    logic [63:0] t2;
    logic        ok;
    assign t3 = rm3[k]
              + (96'(rm2[k]) << (B + 1)) + (96'(rm2[k]) << B)
              + (96'(rm[k]) << (2 * B + 1)) + (96'(rm[k]) << (2 * B))
              + (96'd1 << (3 * B));
    assign t2 = rm2[k] + (64'(rm[k]) << (B + 1)) + (64'd1 << (2 * B));
    assign ok = t3 <= rq[k];

    always_ff @(posedge clk) begin
      if (!rst_n) rv[k+1] <= 1'b0;
      else if (en) rv[k+1] <= rv[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rq[k+1]  <= rq[k];
        rm[k+1]  <= ok ? (rm[k] | (32'd1 << B)) : rm[k];
        rm2[k+1] <= ok ? t2 : rm2[k];
        rm3[k+1] <= ok ? t3 : rm3[k];
        rsd[k+1] <= rsd[k];
      end
    end
  end

  // Rebuild the temperature from the new excess
  assign m_sel = rsd[32].cool ? rm[32] : rsd[32].dr;

  always_ff @(posedge clk) begin
    if (!rst_n) fin_v <= 1'b0;
    else if (en) fin_v <= rv[32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin <= {rsd[32].cool, rsd[32].clamped, cfg.ambient + m_sel};
    end
  end

  assign out_valid = fin_v;
  assign res       = fin;

endmodule

FILE: design/grid_cell_radiative_cooling_unit.sv
// ----------------------------------------------------------------------------
// grid_cell_radiative_cooling_unit: radiative cooling of grid cell temperatures
//
//   Channel  Direction  Payload
//   in_      slave      tdata[31:0] cell_temp
//   out_     master     tdata[31:0] new_temp; tuser[0] was_clamped, [1] was_cooled
//   cfg_     APB slave  4 registers at 0x0, 0x4, 0x8, 0xC (32 bits)
//
// One cell enters per cycle while in_tready is high; each input transaction
// passes 8 front stages, 96 divider stages, 32 cube root stages, one final
// stage and the output buffer before out_tvalid rises. After reset and after
// every register write the factor unit runs with in_tready low, and skips the
// divider when the factor saturates. A 2-entry output buffer decouples
// out_tready from the pipeline; a full buffer stalls all stages.
// ----------------------------------------------------------------------------
module grid_cell_radiative_cooling_unit #(
  parameter int TEMP_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [grcc_pkg::DATA_W-1:0] in_tdata,    // [31:0] cell_temp
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [grcc_pkg::DATA_W-1:0] out_tdata,   // [31:0] new_temp
  output logic [1:0]                  out_tuser,   // [0] was_clamped, [1] was_cooled
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [3:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import grcc_pkg::*;

  cfg_t      cfg_r;
  fac_stat_t fac;
  logic      wr;
  reg_idx_t  widx;
  logic      en, push, pop, pipe_v;
  res_t      pipe_res, sk0_r, sk1_r;
  logic [1:0] cnt_r, cnt_nxt;

  // Register file
  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign widx = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ambient <= 32'd0;
      cfg_r.rate    <= 32'd0;
      cfg_r.hot     <= 32'd65536;
      cfg_r.step    <= 32'd0;
    end else if (wr) begin
      unique case (widx)
        REG_AMBIENT: cfg_r.ambient <= cfg_pwdata;
        REG_RATE:    cfg_r.rate    <= cfg_pwdata;
        REG_HOT:     cfg_r.hot     <= cfg_pwdata;
        REG_STEP:    cfg_r.step    <= cfg_pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_AMBIENT: cfg_prdata = cfg_r.ambient;
      REG_RATE:    cfg_prdata = cfg_r.rate;
      REG_HOT:     cfg_prdata = cfg_r.hot;
      REG_STEP:    cfg_prdata = cfg_r.step;
    endcase
  end

  // Cooling factor, recomputed after each write
  grcc_factor #(.FRAC_BITS(TEMP_FRAC_BITS)) u_factor (
    .clk   (clk),
    .rst_n (rst_n),
    .start (wr),
    .cfg   (cfg_r),
    .stat  (fac)
  );

  // Pipeline advances while the output buffer has room
  assign en        = (cnt_r != 2'd2);
  assign in_tready = en && !fac.busy;

  grcc_pipe #(.FRAC_BITS(TEMP_FRAC_BITS)) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid && in_tready),
    .cell_temp (in_tdata),
    .cfg       (cfg_r),
    .factor    (fac.factor),
    .out_valid (pipe_v),
    .res       (pipe_res)
  );

  // Output buffer, two entries
  assign push       = en && pipe_v;
  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = sk0_r.temp;
  assign out_tuser  = {sk0_r.cooled, sk0_r.clamped};
  assign cnt_nxt    = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    priority if (pop && push) begin
      sk0_r <= (cnt_r == 2'd2) ? sk1_r : pipe_res;
    end else if (pop) begin
      sk0_r <= sk1_r;
    end else if (push) begin
      if (cnt_r == 2'd0) sk0_r <= pipe_res;
      else sk1_r <= pipe_res;
    end
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_wr_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    wr |=> !in_tready)
    else $error("input accepted while factor is recomputed");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("output buffer count did not drop on pop");

endmodule
